### design/rvx_pkg.sv
// Shared types, opcodes and result codes of the RV32IM execute pipeline.
package rvx_pkg;

  typedef enum logic [5:0] {
    OP_LUI    = 6'd0,  OP_AUIPC  = 6'd1,  OP_ADDI   = 6'd2,  OP_SLTI   = 6'd3,
    OP_SLTIU  = 6'd4,  OP_XORI   = 6'd5,  OP_ORI    = 6'd6,  OP_ANDI   = 6'd7,
    OP_SLLI   = 6'd8,  OP_SRLI   = 6'd9,  OP_SRAI   = 6'd10, OP_ADD    = 6'd11,
    OP_SUB    = 6'd12, OP_SLL    = 6'd13, OP_SLT    = 6'd14, OP_SLTU   = 6'd15,
    OP_XOR    = 6'd16, OP_SRL    = 6'd17, OP_SRA    = 6'd18, OP_OR     = 6'd19,
    OP_AND    = 6'd20, OP_MUL    = 6'd21, OP_MULH   = 6'd22, OP_MULHSU = 6'd23,
    OP_MULHU  = 6'd24, OP_DIV    = 6'd25, OP_DIVU   = 6'd26, OP_REM    = 6'd27,
    OP_REMU   = 6'd28, OP_JAL    = 6'd29, OP_JALR   = 6'd30, OP_BEQ    = 6'd31,
    OP_BNE    = 6'd32, OP_BLT    = 6'd33, OP_BGE    = 6'd34, OP_BLTU   = 6'd35,
    OP_BGEU   = 6'd36, OP_LB     = 6'd37, OP_LH     = 6'd38, OP_LW     = 6'd39,
    OP_LBU    = 6'd40, OP_LHU    = 6'd41, OP_SB     = 6'd42, OP_SH     = 6'd43,
    OP_SW     = 6'd44, OP_FENCE  = 6'd45, OP_CSRRW  = 6'd46, OP_CSRRS  = 6'd47,
    OP_CSRRC  = 6'd48, OP_CSRRWI = 6'd49, OP_CSRRSI = 6'd50, OP_CSRRCI = 6'd51,
    OP_ECALL  = 6'd52, OP_EBREAK = 6'd53, OP_MRET   = 6'd54, OP_WFI    = 6'd55
  } op_e;

  localparam logic [5:0] OP_LAST = 6'd55;

  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_STORE = 3'd2;
  localparam logic [2:0] KIND_FENCE = 3'd3;
  localparam logic [2:0] KIND_CSR   = 3'd4;
  localparam logic [2:0] KIND_MRET  = 3'd5;
  localparam logic [2:0] KIND_WFI   = 3'd6;
  localparam logic [2:0] KIND_TRAP  = 3'd7;

  localparam logic [2:0] CAUSE_FETCH_MISALIGN = 3'd0;
  localparam logic [2:0] CAUSE_ILLEGAL        = 3'd1;
  localparam logic [2:0] CAUSE_LOAD_MISALIGN  = 3'd2;
  localparam logic [2:0] CAUSE_STORE_MISALIGN = 3'd3;
  localparam logic [2:0] CAUSE_ECALL          = 3'd4;
  localparam logic [2:0] CAUSE_BREAKPOINT     = 3'd5;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] CSR_REPLACE = 2'd0;
  localparam logic [1:0] CSR_SET     = 2'd1;
  localparam logic [1:0] CSR_CLEAR   = 2'd2;

  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    FIX_NONE   = 3'd0,
    FIX_MUL    = 3'd1,
    FIX_MULH   = 3'd2,
    FIX_MULHSU = 3'd3,
    FIX_MULHU  = 3'd4,
    FIX_QUO    = 3'd5,
    FIX_REM    = 3'd6
  } fix_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] next_pc;
    logic        write_enable;
    logic [4:0]  dest_index;
    logic [31:0] value;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic        sign_extend;
    logic [2:0]  trap_cause;
    logic        csr_read;
    logic        csr_write;
    fix_e        fix;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        div_zero;
    logic        neg_res;
  } item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dq;
    logic [31:0] dsr;
  } div_t;

endpackage

### design/rvx_front.sv
// Decode, ALU, branch, address and trap logic; first pipeline register.
module rvx_front import rvx_pkg::*; #(
  parameter int unsigned ALIGN_BYTES = 4,
  parameter int unsigned INSTR_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [5:0]         op_i,
  input  logic [31:0]        instruction_bits_i,
  input  logic [31:0]        pc_i,
  input  logic [4:0]         rs1_index_i,
  input  logic [4:0]         rs2_index_i,
  input  logic [4:0]         rd_index_i,
  input  logic [31:0]        rs1_value_i,
  input  logic [31:0]        rs2_value_i,
  input  logic signed [31:0] immediate_i,
  input  logic [11:0]        csr_number_i,
  input  logic [7:0]         fence_order_i,
  output logic               valid_o,
  output item_t              item_o,
  output div_t               div_o
);

  // Residue of x modulo ALIGN_BYTES from per-bit residues, then a match
  // against the multiples.
  function automatic logic is_aligned(logic [31:0] x);
    logic [7:0] sum;
    logic       ok;
    sum = 8'd0;
    ok  = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) sum = sum + 8'((64'd1 << i) % ALIGN_BYTES);
    end
    for (int j = 0; j <= 32; j++) begin
      if (sum == 8'(j * ALIGN_BYTES)) ok = 1'b1;
    end
    return ok;
  endfunction

  logic [31:0] a, b, imm, nxt, res, target, addr;
  logic        jump, link, taken;
  logic [1:0]  sz;
  logic        mem_ok;
  op_e         op;
  item_t       it;
  div_t        dv;
  item_t       item_q;
  div_t        div_q;
  logic        valid_q;

  assign a   = (rs1_index_i != 5'd0) ? rs1_value_i : 32'd0;
  assign b   = (rs2_index_i != 5'd0) ? rs2_value_i : 32'd0;
  assign imm = immediate_i;
  assign nxt = pc_i + 32'(INSTR_BYTES);
  assign op  = op_e'(op_i);
  assign addr = a + imm;

  always_comb begin
    case (op)
      OP_LB, OP_LBU, OP_SB: sz = SIZE_BYTE;
      OP_LH, OP_LHU, OP_SH: sz = SIZE_HALF;
      default:              sz = SIZE_WORD;
    endcase
    case (sz)
      SIZE_BYTE: mem_ok = 1'b1;
      SIZE_HALF: mem_ok = ~addr[0];
      default:   mem_ok = (addr[1:0] == 2'd0);
    endcase
  end

  always_comb begin
    it     = '0;
    it.fix = FIX_NONE;
    dv     = '0;
    res    = 32'd0;
    target = 32'd0;
    jump   = 1'b0;
    link   = 1'b0;
    taken  = 1'b0;
    if (!is_aligned(pc_i)) begin
      it.kind = KIND_TRAP; it.next_pc = pc_i;
      it.trap_cause = CAUSE_FETCH_MISALIGN; it.value = pc_i;
    end else if (op_i > OP_LAST) begin
      it.kind = KIND_TRAP; it.next_pc = pc_i;
      it.trap_cause = CAUSE_ILLEGAL; it.value = instruction_bits_i;
    end else begin
      case (op) inside
        [OP_LB:OP_SW]: begin
          if (!mem_ok) begin
            it.kind = KIND_TRAP; it.next_pc = pc_i; it.value = addr;
            it.trap_cause = (op_i >= OP_SB) ? CAUSE_STORE_MISALIGN
                                           : CAUSE_LOAD_MISALIGN;
          end else begin
            it.next_pc = nxt; it.address = addr; it.access_size = sz;
            if (op_i >= OP_SB) begin
              it.kind = KIND_STORE;
              case (sz)
                SIZE_BYTE: it.value = {24'd0, b[7:0]};
                SIZE_HALF: it.value = {16'd0, b[15:0]};
                default:   it.value = b;
              endcase
            end else begin
              it.kind = KIND_LOAD; it.dest_index = rd_index_i;
              it.sign_extend = !(op == OP_LBU || op == OP_LHU);
            end
          end
        end
        [OP_CSRRW:OP_CSRRCI]: begin
          it.kind = KIND_CSR; it.next_pc = nxt; it.dest_index = rd_index_i;
          it.value   = (op_i >= OP_CSRRWI) ? imm : a;
          it.address = {20'd0, csr_number_i};
          case (op)
            OP_CSRRW, OP_CSRRWI: it.access_size = CSR_REPLACE;
            OP_CSRRS, OP_CSRRSI: it.access_size = CSR_SET;
            default:             it.access_size = CSR_CLEAR;
          endcase
          it.csr_read  = (it.access_size != CSR_REPLACE) || (rd_index_i != 5'd0);
          it.csr_write = (it.access_size == CSR_REPLACE) || (rs1_index_i != 5'd0);
        end
        OP_FENCE: begin
          it.kind = KIND_FENCE; it.next_pc = nxt; it.value = {24'd0, fence_order_i};
        end
        OP_ECALL: begin
          it.kind = KIND_TRAP; it.next_pc = pc_i; it.trap_cause = CAUSE_ECALL;
        end
        OP_EBREAK: begin
          it.kind = KIND_TRAP; it.next_pc = pc_i;
          it.trap_cause = CAUSE_BREAKPOINT; it.value = pc_i;
        end
        OP_MRET: begin
          it.kind = KIND_MRET; it.next_pc = nxt;
        end
        OP_WFI: begin
          it.kind = KIND_WFI; it.next_pc = nxt;
        end
        [OP_JAL:OP_BGEU]: begin
          case (op)
            OP_JAL:  begin jump = 1'b1; link = 1'b1; target = pc_i + imm; end
            OP_JALR: begin jump = 1'b1; link = 1'b1; target = addr & ~32'd1; end
            default: begin
              case (op)
                OP_BEQ:  taken = (a == b);
                OP_BNE:  taken = (a != b);
                OP_BLT:  taken = ($signed(a) < $signed(b));
                OP_BGE:  taken = !($signed(a) < $signed(b));
                OP_BLTU: taken = (a < b);
                default: taken = (a >= b);
              endcase
              jump   = taken;
              target = pc_i + imm;
            end
          endcase
          if (!jump) begin
            it.next_pc = nxt;
          end else if (!is_aligned(target)) begin
            it.kind = KIND_TRAP; it.next_pc = pc_i;
            it.trap_cause = CAUSE_FETCH_MISALIGN; it.value = target;
          end else begin
            it.next_pc = target;
            if (link && rd_index_i != 5'd0) begin
              it.write_enable = 1'b1; it.dest_index = rd_index_i; it.value = nxt;
            end
          end
        end
        default: begin
          case (op)
            OP_LUI:   res = imm;
            OP_AUIPC: res = pc_i + imm;
            OP_ADDI:  res = addr;
            OP_SLTI:  res = {31'd0, $signed(a) < $signed(imm)};
            OP_SLTIU: res = {31'd0, a < imm};
            OP_XORI:  res = a ^ imm;
            OP_ORI:   res = a | imm;
            OP_ANDI:  res = a & imm;
            OP_SLLI:  res = a << imm[4:0];
            OP_SRLI:  res = a >> imm[4:0];
            OP_SRAI:  res = 32'($signed(a) >>> imm[4:0]);
            OP_ADD:   res = a + b;
            OP_SUB:   res = a - b;
            OP_SLL:   res = a << b[4:0];
            OP_SLT:   res = {31'd0, $signed(a) < $signed(b)};
            OP_SLTU:  res = {31'd0, a < b};
            OP_XOR:   res = a ^ b;
            OP_SRL:   res = a >> b[4:0];
            OP_SRA:   res = 32'($signed(a) >>> b[4:0]);
            OP_OR:    res = a | b;
            OP_AND:   res = a & b;
            default:  res = 32'd0;
          endcase
          it.next_pc = nxt;
          if (rd_index_i != 5'd0) begin
            it.write_enable = 1'b1; it.dest_index = rd_index_i; it.value = res;
            it.opa = a; it.opb = b; it.div_zero = (b == 32'd0);
            case (op)
              OP_MUL:    it.fix = FIX_MUL;
              OP_MULH:   it.fix = FIX_MULH;
              OP_MULHSU: it.fix = FIX_MULHSU;
              OP_MULHU:  it.fix = FIX_MULHU;
              OP_DIV: begin
                it.fix = FIX_QUO; it.neg_res = a[31] ^ b[31];
                dv.dq  = a[31] ? -a : a; dv.dsr = b[31] ? -b : b;
              end
              OP_REM: begin
                it.fix = FIX_REM; it.neg_res = a[31];
                dv.dq  = a[31] ? -a : a; dv.dsr = b[31] ? -b : b;
              end
              OP_DIVU: begin it.fix = FIX_QUO; dv.dq = a; dv.dsr = b; end
              OP_REMU: begin it.fix = FIX_REM; dv.dq = a; dv.dsr = b; end
              default: it.fix = FIX_NONE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= it;
    div_q  <= dv;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign div_o   = div_q;

endmodule

### design/rvx_div_stage.sv
// One restoring-division step: one quotient bit per stage.
module rvx_div_stage import rvx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  input  div_t  div_i,
  output logic  valid_o,
  output item_t item_o,
  output div_t  div_o
);

  logic [32:0] trial;
  logic        fits;
  div_t        div_d, div_q;
  item_t       item_q;
  logic        valid_q;

  assign trial = {div_i.rem, div_i.dq[31]};
  assign fits  = (trial >= {1'b0, div_i.dsr});

  always_comb begin
    div_d     = div_i;
    div_d.rem = fits ? 32'(trial - {1'b0, div_i.dsr}) : trial[31:0];
    div_d.dq  = {div_i.dq[30:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    div_q  <= div_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign div_o   = div_q;

endmodule

### design/rvx_back.sv
// Multiply, divide fix-up and result select; output register.
module rvx_back import rvx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  input  div_t  div_i,
  output logic  valid_o,
  output item_t item_o
);

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [31:0]        quo, rmd;
  item_t              item_d, item_q;
  logic               valid_q;

  assign ma   = {(item_i.fix == FIX_MULH || item_i.fix == FIX_MULHSU) & item_i.opa[31],
                 item_i.opa};
  assign mb   = {(item_i.fix == FIX_MULH) & item_i.opb[31], item_i.opb};
  assign prod = ma * mb;
  assign quo  = item_i.neg_res ? -div_i.dq : div_i.dq;
  assign rmd  = item_i.neg_res ? -div_i.rem : div_i.rem;

  always_comb begin
    item_d = item_i;
    case (item_i.fix)
      FIX_MUL:                        item_d.value = prod[31:0];
      FIX_MULH, FIX_MULHSU, FIX_MULHU: item_d.value = prod[63:32];
      FIX_QUO: item_d.value = item_i.div_zero ? 32'hFFFF_FFFF : quo;
      FIX_REM: item_d.value = item_i.div_zero ? item_i.opa : rmd;
      default: item_d.value = item_i.value;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### design/rv32im_execute_step.sv
// Top level of the pipelined RV32IM plus Zicsr execute unit.
//
//  channel   ports                        beat taken when
//  --------  ---------------------------  ---------------------------
//  command   start_i, busy_o, op_i ...    start_i high, busy_o low
//  result    done_o, kind_o ... csr_write_o  done_o high (one cycle)
//
// Every instruction passes through the same stages in order: one decode/ALU
// stage, 32 restoring-division stages (one quotient bit each) and one
// multiply/select stage. One beat enters per cycle and results leave in order.
// busy_o stays low: the pipeline never stalls and the receiver cannot stall.
// Reset clears the valid bits of all stages; payload registers hold no reset.
module rv32im_execute_step import rvx_pkg::*; #(
  parameter int unsigned ALIGN_BYTES = 4,
  parameter int unsigned INSTR_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [5:0]         op_i,
  input  logic [31:0]        instruction_bits_i,
  input  logic [31:0]        pc_i,
  input  logic [4:0]         rs1_index_i,
  input  logic [4:0]         rs2_index_i,
  input  logic [4:0]         rd_index_i,
  input  logic [31:0]        rs1_value_i,
  input  logic [31:0]        rs2_value_i,
  input  logic signed [31:0] immediate_i,
  input  logic [11:0]        csr_number_i,
  input  logic [7:0]         fence_order_i,
  output logic               done_o,
  output logic [2:0]         kind_o,
  output logic [31:0]        next_pc_o,
  output logic               write_enable_o,
  output logic [4:0]         dest_index_o,
  output logic [31:0]        value_o,
  output logic [31:0]        address_o,
  output logic [1:0]         access_size_o,
  output logic               sign_extend_o,
  output logic [2:0]         trap_cause_o,
  output logic               csr_read_o,
  output logic               csr_write_o
);

  logic  vld   [DivSteps+1];
  item_t items [DivSteps+1];
  div_t  divs  [DivSteps+1];
  logic  out_vld;
  item_t out_item;

  // Never hold off a command beat.
  assign busy_o = 1'b0;

  rvx_front #(
    .ALIGN_BYTES(ALIGN_BYTES),
    .INSTR_BYTES(INSTR_BYTES)
  ) u_front (
    .clk_i, .rst_ni,
    .valid_i(start_i),
    .op_i, .instruction_bits_i, .pc_i, .rs1_index_i, .rs2_index_i, .rd_index_i,
    .rs1_value_i, .rs2_value_i, .immediate_i, .csr_number_i, .fence_order_i,
    .valid_o(vld[0]),
    .item_o(items[0]),
    .div_o(divs[0])
  );

  // Advance every beat through the divider chain, divide or not, so that
  // latency stays fixed and order is kept.
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    rvx_div_stage u_stage (
      .clk_i, .rst_ni,
      .valid_i(vld[g]),
      .item_i(items[g]),
      .div_i(divs[g]),
      .valid_o(vld[g+1]),
      .item_o(items[g+1]),
      .div_o(divs[g+1])
    );
  end

  rvx_back u_back (
    .clk_i, .rst_ni,
    .valid_i(vld[DivSteps]),
    .item_i(items[DivSteps]),
    .div_i(divs[DivSteps]),
    .valid_o(out_vld),
    .item_o(out_item)
  );

  assign done_o         = out_vld;
  assign kind_o         = out_item.kind;
  assign next_pc_o      = out_item.next_pc;
  assign write_enable_o = out_item.write_enable;
  assign dest_index_o   = out_item.dest_index;
  assign value_o        = out_item.value;
  assign address_o      = out_item.address;
  assign access_size_o  = out_item.access_size;
  assign sign_extend_o  = out_item.sign_extend;
  assign trap_cause_o   = out_item.trap_cause;
  assign csr_read_o     = out_item.csr_read;
  assign csr_write_o    = out_item.csr_write;

endmodule
